// ----- hdl/tmps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared constants and types for the triangle minimum path sum block.
// ----------------------------------------------------------------------------
package tmps_pkg;

  localparam int CFG_BITS = 11;  // num_rows register
  localparam int OUT_BITS = 26;  // min_total field

  // Per-element flags from the sequencer to the update stage
  typedef struct packed {
    logic bottom;  // element of the bottom row: copied, no store reads used
    logic top;     // single top element: result goes out
  } step_flags_t;

endpackage

// ----- hdl/tmps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_if
// Valid/ready channels: triangle elements in, path sums out.
// ----------------------------------------------------------------------------
interface tmps_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tmps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tmps_pkg::OUT_BITS-1:0] min_total;

  modport source (output valid, output min_total, input ready);
  modport sink   (input valid, input min_total, output ready);
endinterface

// ----- hdl/triangle_min_path_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_min_path_sum
// Minimum top-to-bottom path sum of a number triangle, fed bottom row first.
// ----------------------------------------------------------------------------
// Takes one element word per clock, bottom row first, each row left to right;
// num_rows sets the row count (zero acts as one, above MAX_ROWS saturates).
// For each element its two row store entries are read from a dual-read-port
// memory on acceptance and the new sum is written back from the update stage,
// with a forward path when the next element reads the entry just written.
// The top element's result word passes the update stage and sits in an output
// register; input stalls only while a second top element waits behind an
// untaken result. The row store needs no clearing: every entry is written
// before it is read. Writing num_rows restarts the count at the bottom row.
// ----------------------------------------------------------------------------
module triangle_min_path_sum #(
  parameter int MAX_ROWS   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tmps_pkg::CFG_BITS-1:0] cfg_wdata,
  tmps_in_if.sink                       item,
  tmps_out_if.source                    result
);
  import tmps_pkg::*;

  localparam int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW       = $clog2(MAX_ROWS + 1);
  localparam int SUM_BITS = VALUE_BITS + AW + 1;
  localparam int WIDE     = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS;

  logic        accept;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  step_flags_t flags;

  // update stage
  logic                         s1_valid;
  logic signed [VALUE_BITS-1:0] s1_value;
  step_flags_t                  s1_flags;
  logic [AW-1:0]                s1_addr;
  logic                         fwd_a;
  logic                         fwd_b;
  logic signed [SUM_BITS-1:0]   fwd_data;
  logic                         s1_advance;

  logic signed [SUM_BITS-1:0] rdata_a;
  logic signed [SUM_BITS-1:0] rdata_b;
  logic signed [SUM_BITS-1:0] op_a;
  logic signed [SUM_BITS-1:0] op_b;
  logic signed [SUM_BITS-1:0] total;
  logic signed [WIDE-1:0]     total_wide;

  assign s1_advance = s1_valid && !(s1_flags.top && result.valid && !result.ready);
  assign item.ready = !s1_valid || s1_advance;
  assign accept     = item.valid && item.ready;

  tmps_seq #(
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW),
    .RW       (RW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (accept),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .flags     (flags)
  );

  tmps_row_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (SUM_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (s1_advance),
    .waddr   (s1_addr),
    .wdata   (total),
    .re      (accept),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    op_a = fwd_a ? fwd_data : rdata_a;
    op_b = fwd_b ? fwd_data : rdata_b;
    if (s1_flags.bottom) begin
      total = SUM_BITS'(s1_value);
    end else begin
      total = SUM_BITS'(s1_value) + ((op_a < op_b) ? op_a : op_b);
    end
    total_wide = WIDE'(total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Entry being written this edge is read stale by the memory; capture it here
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value <= item.value;
      s1_flags <= flags;
      s1_addr  <= addr_a;
      fwd_a    <= s1_advance && (s1_addr == addr_a);
      fwd_b    <= s1_advance && (s1_addr == addr_b);
      fwd_data <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_advance && s1_flags.top) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_flags.top) begin
      result.min_total <= total_wide[OUT_BITS-1:0];
    end
  end

endmodule

// ----- hdl/tmps_row_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_row_mem
// Row store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tmps_row_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 27,
  parameter int AW    = 10
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [WIDTH-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr_a,
  input  logic [AW-1:0]           raddr_b,
  output logic signed [WIDTH-1:0] rdata_a,
  output logic signed [WIDTH-1:0] rdata_b
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-before-write; the caller forwards same-entry collisions
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/tmps_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_seq
// Row/column sequencer: holds num_rows, tracks position, forms store addresses.
// ----------------------------------------------------------------------------
module tmps_seq #(
  parameter int MAX_ROWS = 1024,
  parameter int AW       = 10,
  parameter int RW       = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tmps_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                          advance,
  output logic [AW-1:0]                 addr_a,
  output logic [AW-1:0]                 addr_b,
  output tmps_pkg::step_flags_t         flags
);
  import tmps_pkg::*;

  localparam int CMPW = (RW > CFG_BITS) ? RW : CFG_BITS;

  logic [CFG_BITS-1:0] num_rows;
  logic [AW-1:0]       row_counter;
  logic [AW-1:0]       column_counter;

  logic [CMPW-1:0] num_ext;
  logic [CMPW-1:0] rows_sat;
  logic [RW-1:0]   rows;
  logic [RW-1:0]   len;
  logic            row_end;

  always_comb begin
    num_ext = CMPW'(num_rows);
    priority if (num_ext == '0) begin
      rows_sat = CMPW'(1);
    end else if (num_ext > CMPW'(MAX_ROWS)) begin
      rows_sat = CMPW'(MAX_ROWS);
    end else begin
      rows_sat = num_ext;
    end
    rows    = rows_sat[RW-1:0];
    len     = rows - RW'(row_counter);
    row_end = (RW'(column_counter) + RW'(1)) == len;
  end

  assign flags.bottom = (row_counter == '0);
  assign flags.top    = (len == RW'(1));
  assign addr_a       = column_counter;
  assign addr_b       = column_counter + AW'(1);  // unused on the bottom row

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows       <= CFG_BITS'(1);
      row_counter    <= '0;
      column_counter <= '0;
    end else if (cfg_we) begin
      num_rows       <= cfg_wdata;
      row_counter    <= '0;
      column_counter <= '0;
    end else if (advance) begin
      priority if (flags.top) begin
        row_counter    <= '0;
        column_counter <= '0;
      end else if (row_end) begin
        row_counter    <= row_counter + AW'(1);
        column_counter <= '0;
      end else begin
        column_counter <= column_counter + AW'(1);
      end
    end
  end

endmodule
